// ----- sv/wsi_pkg.sv -----
// Shared constants, register indexes and controller states of the windowed similarity block.
// No dependencies; every other file of the block imports this package.
package wsi_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = 30;
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_MAX_ROWS   = 1024;
  localparam int DEF_MAX_WINDOW = 8;

  localparam int SAMPLE_W   = 16;
  localparam int POS_OUT_W  = 10;
  localparam int AB_W       = 32;
  localparam int CNT_OUT_W  = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int RESET_ROWS   = 64;
  localparam int RESET_COLS   = 64;
  localparam int RESET_WINDOW = 8;

  // Quotient bits of the ratio divider: two integer bits and FRAC_BITS + 1 fraction bits.
  localparam int QUO_BITS = FRAC_BITS + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1,
    REG_WINDOW_SIZE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_PROD,
    ST_DIFF,
    ST_CHECK,
    ST_DIVA,
    ST_BSET,
    ST_DIVB,
    ST_MUL,
    ST_SCALE,
    ST_TOT,
    ST_MSET,
    ST_MDIV,
    ST_OUT
  } wsi_state_t;

endpackage

// ----- sv/wsi_if.sv -----
// Valid/ready channels of the windowed similarity block: configuration, samples, results.
// Depends on wsi_pkg for the field widths.
interface wsi_cfg_if import wsi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface wsi_sample_if import wsi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_first;
  logic [SAMPLE_W-1:0] sample_second;
  modport source (output valid, sample_first, sample_second, input ready);
  modport sink (input valid, sample_first, sample_second, output ready);
endinterface

interface wsi_result_if import wsi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [POS_OUT_W-1:0]  window_row;
  logic [POS_OUT_W-1:0]  window_col;
  logic signed [AB_W-1:0] window_ab;
  logic                  window_counted;
  logic                  frame_done;
  logic signed [AB_W-1:0] mean_similarity;
  logic [CNT_OUT_W-1:0]  counted_windows;
  logic                  no_counted_windows;
  modport source (output valid, window_row, window_col, window_ab, window_counted, frame_done,
                  mean_similarity, counted_windows, no_counted_windows, input ready);
  modport sink (input valid, window_row, window_col, window_ab, window_counted, frame_done,
                mean_similarity, counted_windows, no_counted_windows, output ready);
endinterface

// ----- sv/windowed_similarity_index_top.sv -----
// Windowed similarity index: a sample word that completes no window leaves the block idle. A word
// that completes a P x P window raises its result word after the read walk (one line-buffer read per
// window sample) and both 33-step ratio divisions, with fewer steps when the window is uncounted or
// b saturates, and after the 53-step mean as well on the last window of a frame.
// The next word is taken in the cycle after the result is loaded, so the read walk and the shared
// divider set the rate. Reset (rst, synchronous) restores 64x64, window 8, clears position/totals.
module windowed_similarity_index_top import wsi_pkg::*; #(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input logic          clk,
  input logic          rst,
  wsi_cfg_if.sink      cfg,
  wsi_sample_if.sink   samples,
  wsi_result_if.source results
);

  // Widths of positions, counts and of the window statistics.
  localparam int RPW  = $clog2(MAX_ROWS);
  localparam int CPW  = $clog2(MAX_COLS);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int PW   = $clog2(MAX_WINDOW + 1);
  localparam int SLW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DEPTH = MAX_WINDOW * MAX_COLS;
  localparam int AW   = $clog2(DEPTH);
  localparam int NW   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SW   = SAMPLE_BITS + NW;
  localparam int QW   = 2 * SAMPLE_BITS + NW;
  localparam int PRW  = 2 * SAMPLE_BITS + 2 * NW;
  localparam int VW   = PRW + 1;
  localparam int DW   = VW + 1;
  localparam int CTW  = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int TW   = FRAC_BITS + 2 + CTW;
  localparam int SCW  = $clog2(TW + 1);
  localparam int MW   = 2 * FRAC_BITS + 4;

  localparam int RST_ROWS = (RESET_ROWS < MAX_ROWS) ? RESET_ROWS : MAX_ROWS;
  localparam int RST_COLS = (RESET_COLS < MAX_COLS) ? RESET_COLS : MAX_COLS;
  localparam int RST_WIN  = (RESET_WINDOW < MAX_WINDOW) ? RESET_WINDOW : MAX_WINDOW;

  localparam logic [QUO_BITS-1:0]  B_CAP = QUO_BITS'(1) << (QUO_BITS - 1);
  localparam logic [FRAC_BITS:0]   ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // Controller state and configuration.
  wsi_state_t state, state_next;
  logic [RCW-1:0] row_count;
  logic [CCW-1:0] column_count;
  logic [PW-1:0]  window_size;

  // Raster position of the next incoming word and its line-buffer slot.
  logic [RPW-1:0] row_pos;
  logic [CPW-1:0] col_pos;
  logic [SLW-1:0] row_slot;

  // Frame totals over counted windows.
  logic signed [TW-1:0] ab_total;
  logic [CTW-1:0]       counted_total;

  // Window being evaluated.
  logic [RPW-1:0] top_row;
  logic [CPW-1:0] left_col;
  logic           last_job;

  // Line-buffer walk.
  logic [SLW-1:0]          rd_slot;
  logic [PW-1:0]           rd_i, rd_j;
  logic                    rd_vld;
  logic [2*SAMPLE_BITS-1:0] rd_data;
  logic [2*SAMPLE_BITS-1:0] row_store [DEPTH];

  // Window sums, products and differences.
  logic [NW-1:0]  acc_n;
  logic [SW-1:0]  acc_s1, acc_s2;
  logic [QW-1:0]  acc_q1, acc_q2, acc_x;
  logic [PRW-1:0] p_nq1, p_nq2, p_nx, p_s11, p_s22, p_s12;
  logic signed [VW-1:0] v1, v2, dn;
  logic [VW-1:0]  a_den;
  logic [DW-1:0]  dn_mag, dd_mag;
  logic           ab_neg, b_sat;

  // Shared ratio divider.
  logic [DW+1:0]     div_e;
  logic [DW:0]       div_d;
  logic [QUO_BITS-1:0] div_q;
  logic [SCW-1:0]    step;
  logic [FRAC_BITS:0] aq;
  logic [MW-1:0]     prod;

  logic signed [AB_W-1:0] ab_val;
  logic                   ab_counted;

  // Mean divider.
  logic [CTW:0]   m_rem;
  logic [TW-1:0]  m_quo;
  logic           m_neg;

  // Output register.
  logic                   out_valid;
  logic [POS_OUT_W-1:0]   out_row, out_col;
  logic signed [AB_W-1:0] out_ab, out_mean;
  logic                   out_counted, out_done, out_none;
  logic [CNT_OUT_W-1:0]   out_cnt;

  // Combinational helpers.
  logic           in_fire, cfg_fire, win_ok, is_last, row_end, out_load;
  logic [PW-1:0]  pm1;
  logic [SLW-1:0] top_slot_c, slot_inc, rd_slot_inc;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] x1, x2;
  logic signed [DW-1:0] dd_c;
  logic           skip_c, div_ge, m_ge, rd_last;
  logic [DW+1:0]  div_sub;
  logic [CTW:0]   m_sh;
  logic [MW-FRAC_BITS-1:0] mag_full;
  logic [FRAC_BITS:0]      mag;
  logic signed [TW:0]      mean_s;

  assign samples.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign in_fire       = samples.valid && samples.ready;
  assign cfg_fire      = cfg.valid && cfg.ready;

  assign pm1     = window_size - PW'(1);
  assign win_ok  = (32'(row_pos) + 32'd1 >= 32'(window_size)) &&
                   (32'(col_pos) + 32'd1 >= 32'(window_size));
  assign row_end = (CCW'(col_pos) + CCW'(1)) >= column_count;
  assign is_last = ((RCW'(row_pos) + RCW'(1)) == row_count) && row_end;

  // Slot of the window's top row, counted back from the current row modulo the buffer depth.
  always_comb begin
    if (32'(row_slot) >= 32'(pm1)) begin
      top_slot_c = SLW'(32'(row_slot) - 32'(pm1));
    end else begin
      top_slot_c = SLW'(32'(row_slot) + MAX_WINDOW - 32'(pm1));
    end
    slot_inc    = (32'(row_slot) == MAX_WINDOW - 1) ? '0 : row_slot + SLW'(1);
    rd_slot_inc = (32'(rd_slot) == MAX_WINDOW - 1) ? '0 : rd_slot + SLW'(1);
  end

  assign wr_addr = AW'(row_slot) * AW'(MAX_COLS) + AW'(col_pos);
  assign rd_addr = AW'(rd_slot) * AW'(MAX_COLS) + AW'(left_col) + AW'(rd_j);
  assign rd_last = (rd_i == pm1) && (rd_j == pm1);

  // Line buffer: one write port for incoming words, one registered read port for the window walk.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_store[wr_addr] <= {samples.sample_second[SAMPLE_BITS-1:0],
                             samples.sample_first[SAMPLE_BITS-1:0]};
    end
    rd_data <= row_store[rd_addr];
  end

  assign x1 = rd_data[SAMPLE_BITS-1:0];
  assign x2 = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // Ratio checks: an empty window, a zero sum or vanishing variances leave the window uncounted.
  assign dd_c   = DW'(v1) + DW'(v2);
  assign skip_c = (acc_n == '0) || (acc_s1 == '0) || (acc_s2 == '0) ||
                  ((v1 == '0) && (v2 == '0)) || (dd_c == '0);

  // One restoring step of the ratio divider: the partial remainder stays below twice the divisor.
  assign div_ge  = div_e >= {1'b0, div_d};
  assign div_sub = div_ge ? (div_e - {1'b0, div_d}) : div_e;

  assign m_sh = {m_rem[CTW-1:0], m_quo[TW-1]};
  assign m_ge = m_sh >= {1'b0, counted_total};

  assign mag_full = prod[MW-1:FRAC_BITS];
  assign mag      = (mag_full > (MW-FRAC_BITS)'(ONE_Q)) ? ONE_Q : mag_full[FRAC_BITS:0];
  assign mean_s   = m_neg ? -$signed({1'b0, m_quo}) : $signed({1'b0, m_quo});

  assign out_load = (state == ST_OUT) && (!out_valid || results.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire && win_ok) begin state_next = ST_READ; end
      ST_READ:  if (rd_last) begin state_next = ST_DRAIN; end
      ST_DRAIN: state_next = ST_PROD;
      ST_PROD:  state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_CHECK;
      ST_CHECK: state_next = skip_c ? ST_TOT : ST_DIVA;
      ST_DIVA:  if (32'(step) == QUO_BITS - 1) begin state_next = ST_BSET; end
      ST_BSET:  state_next = ({1'b0, dn_mag} >= {dd_mag, 1'b0}) ? ST_MUL : ST_DIVB;
      ST_DIVB:  if (32'(step) == QUO_BITS - 1) begin state_next = ST_MUL; end
      ST_MUL:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_TOT;
      ST_TOT:   state_next = last_job ? ST_MSET : ST_OUT;
      ST_MSET:  state_next = (counted_total == '0) ? ST_OUT : ST_MDIV;
      ST_MDIV:  if (32'(step) == TW - 1) begin state_next = ST_OUT; end
      ST_OUT:   if (out_load) begin state_next = ST_IDLE; end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration, position and frame totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= RCW'(RST_ROWS);
      column_count  <= CCW'(RST_COLS);
      window_size   <= PW'(RST_WIN);
      row_pos       <= '0;
      col_pos       <= '0;
      row_slot      <= '0;
      ab_total      <= '0;
      counted_total <= '0;
    end else if (cfg_fire) begin
      // A write to any listed register clamps the value and restarts the frame.
      if (cfg.index == REG_ROW_COUNT || cfg.index == REG_COLUMN_COUNT ||
          cfg.index == REG_WINDOW_SIZE) begin
        row_pos       <= '0;
        col_pos       <= '0;
        row_slot      <= '0;
        ab_total      <= '0;
        counted_total <= '0;
      end
      if (cfg.index == REG_ROW_COUNT) begin
        row_count <= (cfg.data == '0) ? RCW'(1) :
                     (32'(cfg.data) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(cfg.data);
      end
      if (cfg.index == REG_COLUMN_COUNT) begin
        column_count <= (cfg.data == '0) ? CCW'(1) :
                        (32'(cfg.data) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cfg.data);
      end
      if (cfg.index == REG_WINDOW_SIZE) begin
        window_size <= (cfg.data == '0) ? PW'(1) :
                       (32'(cfg.data) > MAX_WINDOW) ? PW'(MAX_WINDOW) : PW'(cfg.data);
      end
    end else begin
      if (in_fire) begin
        if (is_last) begin
          row_pos  <= '0;
          col_pos  <= '0;
          row_slot <= '0;
          // A last word that completes no window ends the frame at once.
          if (!win_ok) begin
            ab_total      <= '0;
            counted_total <= '0;
          end
        end else if (row_end) begin
          col_pos  <= '0;
          row_pos  <= row_pos + RPW'(1);
          row_slot <= slot_inc;
        end else begin
          col_pos <= col_pos + CPW'(1);
        end
      end
      if (state == ST_TOT && ab_counted) begin
        ab_total      <= ab_total + TW'(ab_val);
        counted_total <= counted_total + CTW'(1);
      end
      if (out_load && last_job) begin
        ab_total      <= '0;
        counted_total <= '0;
      end
    end
  end

  // Window datapath: sums over the line buffer, then the two ratios and their product.
  always_ff @(posedge clk) begin
    rd_vld <= (state == ST_READ);
    if (in_fire) begin
      top_row  <= RPW'(32'(row_pos) + 32'd1 - 32'(window_size));
      left_col <= CPW'(32'(col_pos) + 32'd1 - 32'(window_size));
      last_job <= is_last;
      rd_slot  <= top_slot_c;
      rd_i     <= '0;
      rd_j     <= '0;
      acc_n    <= '0;
      acc_s1   <= '0;
      acc_s2   <= '0;
      acc_q1   <= '0;
      acc_q2   <= '0;
      acc_x    <= '0;
    end
    if (state == ST_READ) begin
      if (rd_j == pm1) begin
        rd_j    <= '0;
        rd_i    <= rd_i + PW'(1);
        rd_slot <= rd_slot_inc;
      end else begin
        rd_j <= rd_j + PW'(1);
      end
    end
    if (rd_vld) begin
      acc_n  <= acc_n + NW'(x1 != '0);
      acc_s1 <= acc_s1 + SW'(x1);
      acc_s2 <= acc_s2 + SW'(x2);
      acc_q1 <= acc_q1 + QW'(x1 * x1);
      acc_q2 <= acc_q2 + QW'(x2 * x2);
      acc_x  <= acc_x + QW'(x1 * x2);
    end
    unique case (state)
      ST_PROD: begin
        p_nq1 <= PRW'(acc_n * acc_q1);
        p_nq2 <= PRW'(acc_n * acc_q2);
        p_nx  <= PRW'(acc_n * acc_x);
        p_s11 <= PRW'(acc_s1 * acc_s1);
        p_s22 <= PRW'(acc_s2 * acc_s2);
        p_s12 <= PRW'(acc_s1 * acc_s2);
      end
      ST_DIFF: begin
        v1    <= $signed({1'b0, p_nq1}) - $signed({1'b0, p_s11});
        v2    <= $signed({1'b0, p_nq2}) - $signed({1'b0, p_s22});
        dn    <= $signed({1'b0, p_nx}) - $signed({1'b0, p_s12});
        a_den <= VW'(p_s11) + VW'(p_s22);
      end
      ST_CHECK: begin
        dn_mag     <= dn[VW-1] ? DW'(-DW'(dn)) : DW'(dn);
        dd_mag     <= dd_c[DW-1] ? DW'(-dd_c) : DW'(dd_c);
        ab_neg     <= dn[VW-1] != dd_c[DW-1];
        div_e      <= (DW+2)'(p_s12);
        div_d      <= {1'b0, a_den, 1'b0};
        div_q      <= '0;
        step       <= '0;
        ab_val     <= '0;
        ab_counted <= 1'b0;
      end
      ST_DIVA, ST_DIVB: begin
        div_e <= {div_sub[DW:0], 1'b0};
        div_q <= {div_q[QUO_BITS-2:0], div_ge};
        step  <= step + SCW'(1);
      end
      ST_BSET: begin
        aq    <= div_q[FRAC_BITS:0];
        b_sat <= {1'b0, dn_mag} >= {dd_mag, 1'b0};
        div_e <= (DW+2)'(dn_mag);
        div_d <= {dd_mag, 1'b0};
        div_q <= '0;
        step  <= '0;
      end
      ST_MUL: begin
        prod <= MW'(aq * (b_sat ? B_CAP : div_q));
      end
      ST_SCALE: begin
        ab_val     <= ab_neg ? -AB_W'(mag) : AB_W'(mag);
        ab_counted <= 1'b1;
      end
      ST_MSET: begin
        m_neg <= ab_total[TW-1];
        m_quo <= ab_total[TW-1] ? TW'(-ab_total) : TW'(ab_total);
        m_rem <= '0;
        step  <= '0;
      end
      ST_MDIV: begin
        m_rem <= m_ge ? (m_sh - {1'b0, counted_total}) : m_sh;
        m_quo <= {m_quo[TW-2:0], m_ge};
        step  <= step + SCW'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished result waits here while the next word is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row     <= POS_OUT_W'(top_row);
      out_col     <= POS_OUT_W'(left_col);
      out_ab      <= ab_val;
      out_counted <= ab_counted;
      out_done    <= last_job;
      out_mean    <= last_job ? AB_W'(mean_s) : '0;
      out_cnt     <= last_job ? CNT_OUT_W'(counted_total) : '0;
      out_none    <= last_job && (counted_total == '0);
    end
  end

  assign results.valid              = out_valid;
  assign results.window_row         = out_row;
  assign results.window_col         = out_col;
  assign results.window_ab          = out_ab;
  assign results.window_counted     = out_counted;
  assign results.frame_done         = out_done;
  assign results.mean_similarity    = out_mean;
  assign results.counted_windows    = out_cnt;
  assign results.no_counted_windows = out_none;

endmodule

// ----- sv/wsi_checker.sv -----
// Port-level checks of the windowed similarity block and the bind that attaches them.
// Depends on wsi_pkg and on windowed_similarity_index_top.
module wsi_checker import wsi_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [AB_W-1:0] window_ab,
  input logic                   window_counted,
  input logic                   frame_done,
  input logic signed [AB_W-1:0] mean_similarity,
  input logic [CNT_OUT_W-1:0]   counted_windows,
  input logic                   no_counted_windows
);

  localparam logic signed [AB_W-1:0] ONE_V = AB_W'(1) << FRAC_BITS;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_ab))
    else $error("result word changed while stalled");

  a_uncounted_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_counted |-> window_ab == '0)
    else $error("uncounted window carries a nonzero value");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_counted |-> window_ab <= ONE_V && window_ab >= -ONE_V)
    else $error("window value outside plus or minus one");

  a_frame_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |->
      mean_similarity == '0 && counted_windows == '0 && !no_counted_windows)
    else $error("frame fields set on a word that does not end the frame");

  a_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_counted_windows |-> counted_windows == '0 && mean_similarity == '0)
    else $error("empty frame reports a count or a mean");

endmodule

bind windowed_similarity_index_top wsi_checker u_wsi_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (results.valid),
  .out_ready          (results.ready),
  .window_ab          (results.window_ab),
  .window_counted     (results.window_counted),
  .frame_done         (results.frame_done),
  .mean_similarity    (results.mean_similarity),
  .counted_windows    (results.counted_windows),
  .no_counted_windows (results.no_counted_windows)
);

// ----- test/windowed_similarity_index_top_tb.sv -----
// Self-checking testbench of windowed_similarity_index_top: streams image frames of sample
// words, predicts every window result in SystemVerilog and checks the result words in order.
// Depends on wsi_pkg and the channel interfaces in wsi_if.sv.
`timescale 1ns / 100ps

module windowed_similarity_index_top_tb;
  import wsi_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int SETTLE_GAP   = 300;     // covers the slowest window plus the frame mean
  localparam int STALL_LIMIT  = 50000;   // cycles with no handshake on any channel before giving up
  localparam int LINE_ROWS    = DEF_MAX_WINDOW;
  localparam int LINE_COLS    = DEF_MAX_COLS;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] first;
    logic [SAMPLE_W-1:0] second;
  } pixel_pair_t;

  typedef struct {
    logic [POS_OUT_W-1:0]   row;
    logic [POS_OUT_W-1:0]   col;
    logic signed [AB_W-1:0] ab;
    logic                   counted;
    logic                   done;
    logic signed [AB_W-1:0] mean;
    logic [CNT_OUT_W-1:0]   total;
    logic                   none;
  } window_result_t;

  logic clk;
  logic rst;

  wsi_cfg_if    cfg_ch ();
  wsi_sample_if pix_ch ();
  wsi_result_if res_ch ();

  windowed_similarity_index_top uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (pix_ch),
    .results (res_ch)
  );

  // Words waiting to be driven, and window results predicted but not yet seen.
  pixel_pair_t    pixel_queue[$];
  window_result_t window_queue[$];

  int  send_idle_pct;
  int  stall_pct;
  bit  word_taken;
  int  error_count;
  int  quiet_cycles;
  int  items_queued;

  // Predictor copy of the block: configuration, line buffer, position and frame totals.
  int          img_rows, img_cols, win_side;
  int          row_pos, col_pos;
  longint      ab_total;
  int          counted_total;
  logic [31:0] line_buf [LINE_ROWS][LINE_COLS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(x * 2^(FRAC_BITS+1) / den), saturated to cap.
  function automatic logic [63:0] scaled_ratio(input logic [63:0] x, input logic [63:0] den,
                                               input logic [63:0] cap);
    logic [127:0] quo;
    quo = ({64'd0, x} << (FRAC_BITS + 1)) / {64'd0, den};
    return (quo > {64'd0, cap}) ? cap : quo[63:0];
  endfunction

  // Similarity product a*b of one window from its sums; uncounted windows give zero.
  function automatic void window_similarity(input longint n, input longint s1, input longint s2,
                                            input longint q1, input longint q2, input longint x,
                                            output logic signed [AB_W-1:0] ab,
                                            output logic counted);
    longint      v1, v2, dd, dn;
    logic [63:0] aq, bq, mag, one;
    bit          neg;
    ab = '0;
    counted = 1'b0;
    one = 64'd1 << FRAC_BITS;
    if (n == 0 || s1 == 0 || s2 == 0) return;
    v1 = n * q1 - s1 * s1;
    v2 = n * q2 - s2 * s2;
    if (v1 == 0 && v2 == 0) return;
    dd = v1 + v2;
    if (dd == 0) return;
    dn = n * x - s1 * s2;
    aq = scaled_ratio(s1 * s2, s1 * s1 + s2 * s2, one);
    neg = (dn < 0) != (dd < 0);
    bq = scaled_ratio((dn < 0) ? -dn : dn, (dd < 0) ? -dd : dd, 64'd1 << (62 - FRAC_BITS));
    mag = (aq * bq) >> FRAC_BITS;
    if (mag > one) mag = one;
    ab = neg ? -AB_W'(mag) : AB_W'(mag);
    counted = 1'b1;
  endfunction

  function automatic int clamp_value(input int value, input int top);
    return (value < 1) ? 1 : ((value > top) ? top : value);
  endfunction

  // Advances the predictor by one accepted word and queues the window it completes, if any.
  task automatic predict_window(input pixel_pair_t px);
    int             top, left;
    bit             last;
    longint         n, s1, s2, q1, q2, x, a, b;
    window_result_t res;
    last = (row_pos + 1 == img_rows) && (col_pos + 1 == img_cols);
    line_buf[row_pos % LINE_ROWS][col_pos % LINE_COLS] = {px.second, px.first};
    if (row_pos + 1 >= win_side && col_pos + 1 >= win_side) begin
      top = row_pos + 1 - win_side;
      left = col_pos + 1 - win_side;
      n = 0; s1 = 0; s2 = 0; q1 = 0; q2 = 0; x = 0;
      for (int i = 0; i < win_side; i++) begin
        for (int j = 0; j < win_side; j++) begin
          a = line_buf[(top + i) % LINE_ROWS][(left + j) % LINE_COLS][15:0];
          b = line_buf[(top + i) % LINE_ROWS][(left + j) % LINE_COLS][31:16];
          if (a > 0) n++;
          s1 += a; s2 += b; q1 += a * a; q2 += b * b; x += a * b;
        end
      end
      window_similarity(n, s1, s2, q1, q2, x, res.ab, res.counted);
      if (res.counted) begin
        ab_total += res.ab;
        counted_total++;
      end
      res.row = POS_OUT_W'(top);
      res.col = POS_OUT_W'(left);
      res.done = last;
      res.mean = '0;
      res.total = '0;
      res.none = 1'b0;
      if (last) begin
        res.mean = (counted_total != 0) ? AB_W'(ab_total / longint'(counted_total)) : '0;
        res.total = CNT_OUT_W'(counted_total);
        res.none = (counted_total == 0);
      end
      window_queue.push_back(res);
    end
    if (last) begin
      row_pos = 0; col_pos = 0; ab_total = 0; counted_total = 0;
    end else if (col_pos + 1 >= img_cols) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
  endtask

  // Monitor: configuration writes, accepted sample words and result words, all at the rising edge.
  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      img_rows = RESET_ROWS; img_cols = RESET_COLS; win_side = RESET_WINDOW;
      row_pos = 0; col_pos = 0; ab_total = 0; counted_total = 0;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_ch.valid && cfg_ch.ready) begin
        quiet_cycles = 0;
        if (cfg_ch.index != REG_UNUSED) begin
          case (cfg_ch.index)
            REG_ROW_COUNT:    img_rows = clamp_value(cfg_ch.data, DEF_MAX_ROWS);
            REG_COLUMN_COUNT: img_cols = clamp_value(cfg_ch.data, DEF_MAX_COLS);
            default:          win_side = clamp_value(cfg_ch.data, DEF_MAX_WINDOW);
          endcase
          // Any valid write restarts the frame.
          row_pos = 0; col_pos = 0; ab_total = 0; counted_total = 0;
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        quiet_cycles = 0;
        word_taken = 1'b1;
        predict_window({pix_ch.sample_first, pix_ch.sample_second});
      end
      if (res_ch.valid && res_ch.ready) begin
        quiet_cycles = 0;
        if (window_queue.size() == 0) begin
          $error("result word with no window expected (row %0d col %0d)",
                 res_ch.window_row, res_ch.window_col);
          error_count++;
        end else begin
          want = window_queue.pop_front();
          if (res_ch.window_row !== want.row) begin
            $error("window_row: expected %0d, got %0d", want.row, res_ch.window_row);
            error_count++;
          end
          if (res_ch.window_col !== want.col) begin
            $error("window_col: expected %0d, got %0d", want.col, res_ch.window_col);
            error_count++;
          end
          if (res_ch.window_ab !== want.ab) begin
            $error("window_ab: expected %0d, got %0d", want.ab, res_ch.window_ab);
            error_count++;
          end
          if (res_ch.window_counted !== want.counted) begin
            $error("window_counted: expected %0d, got %0d", want.counted, res_ch.window_counted);
            error_count++;
          end
          if (res_ch.frame_done !== want.done) begin
            $error("frame_done: expected %0d, got %0d", want.done, res_ch.frame_done);
            error_count++;
          end
          if (res_ch.mean_similarity !== want.mean) begin
            $error("mean_similarity: expected %0d, got %0d", want.mean, res_ch.mean_similarity);
            error_count++;
          end
          if (res_ch.counted_windows !== want.total) begin
            $error("counted_windows: expected %0d, got %0d", want.total, res_ch.counted_windows);
            error_count++;
          end
          if (res_ch.no_counted_windows !== want.none) begin
            $error("no_counted_windows: expected %0d, got %0d", want.none,
                   res_ch.no_counted_windows);
            error_count++;
          end
        end
      end
      // A stuck handshake anywhere ends the run here.
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Driver: the next word goes out at the falling edge once the previous one was taken.
  always @(negedge clk) begin
    pixel_pair_t px;
    if (rst) begin
      pix_ch.valid <= 1'b0;
      res_ch.ready <= 1'b0;
    end else begin
      if (!pix_ch.valid || word_taken) begin
        word_taken = 1'b0;
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          px = pixel_queue.pop_front();
          pix_ch.valid <= 1'b1;
          pix_ch.sample_first <= px.first;
          pix_ch.sample_second <= px.second;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Waits until every word is sent and every window has come back, then a settle gap for the block to go idle.
  task automatic drain_block();
    while (pixel_queue.size() > 0 || pix_ch.valid || window_queue.size() > 0)
      @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_frame(input int rows, input int cols, input int side);
    write_register(REG_ROW_COUNT, rows);
    write_register(REG_COLUMN_COUNT, cols);
    write_register(REG_WINDOW_SIZE, side);
  endtask

  // Sample pair drawn from one of several content styles, so that degenerate windows
  // (all-zero, flat, anti-correlated, cancelling variances) come up often.
  function automatic pixel_pair_t random_pixel(input int style);
    pixel_pair_t px;
    px.first = 16'($urandom);
    px.second = 16'($urandom);
    case (style)
      1: begin
        px.first = 16'($urandom_range(3));
        px.second = 16'($urandom_range(3));
      end
      2: px.second = px.first;
      3: px.second = ~px.first;
      4: if ($urandom_range(1)) px.first = '0;
      5: begin
        px.first = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        px.second = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic queue_pixels(input int count, input int style);
    for (int i = 0; i < count; i++) begin
      pixel_queue.push_back(random_pixel(style));
      items_queued++;
    end
  endtask

  initial begin
    int rows, cols, side, frames, style, part;
    pixel_pair_t directed [16];
    rst = 1'b1;
    send_idle_pct = 0;
    stall_pct = 0;
    word_taken = 1'b0;
    error_count = 0;
    items_queued = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ROW_COUNT;
    cfg_ch.data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.sample_first = '0;
    pix_ch.sample_second = '0;
    res_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frame, 4x4 with a 2x2 window: an all-zero window, full-scale flat windows,
    // a zero second image, a zero-heavy first image and a mixed patch.
    directed = '{'{16'd0, 16'd0}, '{16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'hFFFF},
                 '{16'd0, 16'd0}, '{16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'hFFFF},
                 '{16'd5, 16'd0}, '{16'd5, 16'd0}, '{16'd1, 16'd2}, '{16'd3, 16'd4},
                 '{16'd5, 16'd0}, '{16'd0, 16'd0}, '{16'd4, 16'd1}, '{16'd2, 16'd3}};
    set_frame(4, 4, 2);
    foreach (directed[i]) pixel_queue.push_back(directed[i]);
    drain_block();

    // Out-of-range register values clamp: 1024 rows of one column never fill a window.
    set_frame(2047, 0, 15);
    queue_pixels(20, 0);
    drain_block();
    // One row of 1024 columns with a 1x1 window: every word is a flat, uncounted window.
    set_frame(0, 2047, 0);
    queue_pixels(30, 0);
    drain_block();
    // The widest window over tall narrow images, cut short by the next write.
    set_frame(1024, 8, 8);
    queue_pixels(70, 0);
    drain_block();
    // A write to the unused index changes nothing; a window larger than the image yields nothing.
    write_register(REG_UNUSED, 5);
    set_frame(3, 3, 5);
    queue_pixels(9, 0);
    drain_block();

    // Random frames, idling style rotating every four configurations.
    part = 0;
    while (items_queued < ITEM_TARGET) begin
      case ((part / 4) % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      side = $urandom_range(1, 4);
      rows = $urandom_range(side, side + 4);
      cols = $urandom_range(side, side + 4);
      if ($urandom_range(9) == 0) begin
        side = $urandom_range(5, 8);
        rows = $urandom_range(side, 10);
        cols = $urandom_range(side, 12);
      end else if ($urandom_range(9) == 0) begin
        rows = $urandom_range(1, 3);
        cols = $urandom_range(10, 40);
      end
      set_frame(rows, cols, side);
      frames = $urandom_range(1, 2);
      for (int f = 0; f < frames; f++) begin
        style = $urandom_range(5);
        queue_pixels(rows * cols, style);
      end
      // Now and then a broken frame: a partial one that the next write abandons.
      if ($urandom_range(7) == 0) queue_pixels($urandom_range(1, rows * cols), 0);
      drain_block();
      part++;
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
